@@ rtl/bracket_balance_checker_macros.svh @@
`ifndef BRACKET_BALANCE_CHECKER_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    localparam int STACK_DEPTH_DEF   = 1024;
    localparam int POSITION_BITS_DEF = 20;
    localparam int CHAR_W            = 8;
    localparam int POS_FIELD_W       = 20;
    localparam int OUT_DATA_W        = 24;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_CLOSER = 2'd1,
        ST_UNCLOSED   = 2'd2,
        ST_OVERFLOW   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_OPEN  = 2'd1,
        CLS_CLOSE = 2'd2
    } t_cls;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } t_kind;

    typedef struct packed {
        t_cls  cls;
        t_kind kind;
        logic  last;
    } t_tag;

endpackage

`default_nettype wire

@@ rtl/bbc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bbc_front
    import bbc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [CHAR_W-1:0]        i_char,
    input  wire logic                     i_last,
    input  wire logic                     i_q_full,
    output logic                          o_ready,
    output logic                          o_wr,
    output t_tag                          o_tag,
    output logic      [POSITION_BITS-1:0] o_pos
);

    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;

    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;

    assign o_ready = !i_q_full;
    assign o_wr    = i_valid && !i_q_full;

    always_comb begin
        o_tag.last = i_last;
        unique case (i_char)
            CH_OPEN_ROUND: begin
                o_tag.cls  = CLS_OPEN;
                o_tag.kind = KIND_ROUND;
            end
            CH_OPEN_SQUARE: begin
                o_tag.cls  = CLS_OPEN;
                o_tag.kind = KIND_SQUARE;
            end
            CH_OPEN_CURLY: begin
                o_tag.cls  = CLS_OPEN;
                o_tag.kind = KIND_CURLY;
            end
            CH_CLOSE_ROUND: begin
                o_tag.cls  = CLS_CLOSE;
                o_tag.kind = KIND_ROUND;
            end
            CH_CLOSE_SQUARE: begin
                o_tag.cls  = CLS_CLOSE;
                o_tag.kind = KIND_SQUARE;
            end
            CH_CLOSE_CURLY: begin
                o_tag.cls  = CLS_CLOSE;
                o_tag.kind = KIND_CURLY;
            end
            default: begin
                o_tag.cls  = CLS_OTHER;
                o_tag.kind = KIND_ROUND;
            end
        endcase
    end

    // The position counter sticks at its all-ones value on very long strings.
    always_comb begin
        n_pos = (r_pos == '1) ? r_pos : r_pos + 1'b1;
    end

    assign o_pos = n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_wr) begin
            r_pos <= i_last ? '0 : n_pos;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bbc_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_rd,
    output logic                  o_valid,
    output logic                  o_full,
    output logic      [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bbc_back
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire t_tag                     i_tag,
    input  wire logic [POSITION_BITS-1:0] i_pos,
    output logic                          o_q_take,
    output logic                          o_m_valid,
    input  wire logic                     i_m_ready,
    output t_status                       o_status,
    output logic      [POS_FIELD_W-1:0]   o_position
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // The top entry lives in r_top; the entry below it comes either from the
    // RAM read port or, right after a push, from r_second_fwd.
    logic [CNT_W-1:0]         r_count,        n_count;
    t_kind                    r_top,          n_top;
    t_kind                    r_second_fwd,   n_second_fwd;
    logic                     r_use_fwd,      n_use_fwd;
    logic [POSITION_BITS-1:0] r_first_open,   n_first_open;
    logic                     r_err,          n_err;
    t_status                  r_err_status,   n_err_status;
    logic [POSITION_BITS-1:0] r_err_pos,      n_err_pos;
    logic                     r_out_valid,    n_out_valid;
    t_status                  r_out_status,   n_out_status;
    logic [POS_FIELD_W-1:0]   r_out_pos,      n_out_pos;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [1:0]        ram_rdata;
    t_kind             second;

    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_top),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign second   = r_use_fwd ? r_second_fwd : t_kind'(ram_rdata);
    assign o_q_take = i_q_valid && (!i_tag.last || !r_out_valid || i_m_ready);

    always_comb begin
        n_count      = r_count;
        n_top        = r_top;
        n_second_fwd = r_second_fwd;
        n_use_fwd    = r_use_fwd;
        n_first_open = r_first_open;
        n_err        = r_err;
        n_err_status = r_err_status;
        n_err_pos    = r_err_pos;
        n_out_valid  = r_out_valid && !i_m_ready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        ram_we       = 1'b0;
        ram_waddr    = ADDR_W'(r_count - 1'b1);
        ram_re       = 1'b0;
        ram_raddr    = ADDR_W'(r_count - CNT_W'(3));

        if (o_q_take && !r_err) begin
            unique case (i_tag.cls)
                CLS_CLOSE: begin
                    if (r_count == '0 || r_top != i_tag.kind) begin
                        n_err        = 1'b1;
                        n_err_status = ST_BAD_CLOSER;
                        n_err_pos    = i_pos;
                    end else begin
                        n_count   = r_count - 1'b1;
                        n_top     = second;
                        n_use_fwd = 1'b0;
                        ram_re    = (r_count >= CNT_W'(3));
                    end
                end
                CLS_OPEN: begin
                    if (r_count == CNT_W'(STACK_DEPTH)) begin
                        n_err        = 1'b1;
                        n_err_status = ST_OVERFLOW;
                        n_err_pos    = i_pos;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_top   = i_tag.kind;
                        if (r_count == '0) begin
                            n_first_open = i_pos;
                        end else begin
                            ram_we       = 1'b1;
                            n_second_fwd = r_top;
                            n_use_fwd    = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (o_q_take && i_tag.last) begin
            n_out_valid = 1'b1;
            if (n_err) begin
                n_out_status = n_err_status;
                n_out_pos    = POS_FIELD_W'(n_err_pos);
            end else if (n_count == '0) begin
                n_out_status = ST_OK;
                n_out_pos    = '0;
            end else begin
                n_out_status = ST_UNCLOSED;
                n_out_pos    = POS_FIELD_W'(n_first_open);
            end
            n_count = '0;
            n_err   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_use_fwd   <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_use_fwd   <= n_use_fwd;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_second_fwd <= n_second_fwd;
        r_first_open <= n_first_open;
        r_err_status <= n_err_status;
        r_err_pos    <= n_err_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    assign o_m_valid  = r_out_valid;
    assign o_status   = r_out_status;
    assign o_position = r_out_pos;

endmodule

`default_nettype wire

@@ rtl/bracket_balance_checker.sv @@
// Channel   Direction  Payload                               Marker
// s_axis    in         tdata[7:0] char_code                  tlast = last_char
// m_axis    out        tdata[19:0] position, [23:20] zero    tuser[1:0] = status
//
// One character is taken per cycle while no last character is held back by m_axis;
// pushes and pops never stall, as the top of stack sits in a register beside the
// stack RAM. A verdict drives m_axis_tvalid in the cycle after the stack stage
// takes its last character; that is held while an earlier verdict waits on m_axis.
// Reset is synchronous and clears the counters and flags; the stack RAM needs no clearing.
// A stalled m_axis holds back only a new last character; others keep flowing
// until the two-entry queue between the classifier and the stack fills.
`timescale 1ns / 1ps
`default_nettype none
`include "bracket_balance_checker_macros.svh"

module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_code
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,   // [19:0] position
    output logic      [1:0]            m_axis_tuser    // [1:0] status
);

    localparam int Q_W = POSITION_BITS + $bits(t_tag);

    logic                     f_wr;
    t_tag                     f_tag;
    logic [POSITION_BITS-1:0] f_pos;
    logic                     q_full;
    logic                     q_valid;
    logic                     q_take;
    logic [Q_W-1:0]           q_data;
    t_tag                     q_tag;
    logic [POSITION_BITS-1:0] q_pos;
    t_status                  b_status;
    logic [POS_FIELD_W-1:0]   b_position;

    bbc_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_full (q_full),
        .o_ready  (s_axis_tready),
        .o_wr     (f_wr),
        .o_tag    (f_tag),
        .o_pos    (f_pos)
    );

    bbc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_data  ({f_pos, f_tag}),
        .i_rd    (q_take),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    assign q_tag = t_tag'(q_data[$bits(t_tag)-1:0]);
    assign q_pos = q_data[Q_W-1:$bits(t_tag)];

    bbc_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_tag      (q_tag),
        .i_pos      (q_pos),
        .o_q_take   (q_take),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_status   (b_status),
        .o_position (b_position)
    );

    assign m_axis_tdata = OUT_DATA_W'(b_position);
    assign m_axis_tuser = b_status;

    // Positions are 1-based, so an accepted character never carries zero.
    `BBC_ASSERT_IMP(a_pos_nonzero, s_axis_tvalid && s_axis_tready, f_pos != '0,
        "accepted character carries position zero")
    `BBC_ASSERT_IMP(a_ok_pos_zero, m_axis_tvalid && (m_axis_tuser == ST_OK),
        m_axis_tdata[POS_FIELD_W-1:0] == '0, "success verdict with nonzero position")
    `BBC_ASSERT_IMP(a_verdict_from_last, $rose(m_axis_tvalid),
        $past(q_take && q_tag.last), "verdict raised without a last character")

endmodule

`default_nettype wire
